>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication across reset");

`endif

>>> hdl/ppu_pkg.sv
// ---------------------------------------------------------------------------
// ppu_pkg
// types and constants of the picture-unit register port
// ---------------------------------------------------------------------------
package ppu_pkg;

  // request kinds; the fourth code is ignored
  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_STATUS = 2'd2
  } req_kind_t;

  // register offsets
  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_ADDR = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_idx_t;

  // address map
  localparam logic [15:0] ADDR_MASK    = 16'h3FFF;
  localparam logic [15:0] NT_BASE      = 16'h2000;
  localparam logic [15:0] NT_END       = 16'h3000;
  localparam logic [15:0] PAL_BASE     = 16'h3F00;
  localparam logic [15:0] PAL_MIR_LAST = 16'h3F1C;
  localparam logic [15:0] PAL_MIR_STEP = 16'h0010;
  localparam logic [15:0] NT_STEP_VERT = 16'h0800;
  localparam logic [15:0] NT_STEP_HORZ = 16'h0400;
  localparam logic [15:0] STEP_ROW     = 16'd32;
  localparam logic [15:0] STEP_ONE     = 16'd1;

  // ctrl / status bits
  localparam int CTRL_INC_BIT  = 2;
  localparam int CTRL_NMI_BIT  = 7;
  localparam int STATUS_VBLANK = 7;

  // work handed from the latch stage to the response stage
  typedef struct packed {
    logic [7:0]  read_data;
    logic        nmi;
    logic [15:0] vram_addr;
    logic [14:0] temp_addr;
    logic [2:0]  fine_x;
    logic        vram_rd;
    logic        pal_rd;
    logic        oam_rd;
    logic        mirror_wr;
    logic [7:0]  wdata;
  } issue_t;

  // memory access requests of one transfer
  typedef struct packed {
    logic vram_we;
    logic vram_re;
    logic oam_we;
    logic oam_re;
  } mem_req_t;

endpackage

>>> hdl/ppu_ram.sv
// ---------------------------------------------------------------------------
// ppu_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module ppu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port, read port returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/ppu_latch.sv
// ---------------------------------------------------------------------------
// ppu_latch
// register shadows, scroll/address latches and memory request decode
// ---------------------------------------------------------------------------
module ppu_latch #(
  parameter int VRAM_AW = 14,
  parameter int OAM_AW  = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [1:0]           req_type,
  input  logic [2:0]           reg_index,
  input  logic [7:0]           write_data,
  input  logic                 mirroring_mode,
  output ppu_pkg::issue_t      issue,
  output ppu_pkg::mem_req_t    mreq,
  output logic [VRAM_AW-1:0]   vram_addr,
  output logic [VRAM_AW-1:0]   mirror_addr,
  output logic [OAM_AW-1:0]    oam_addr
);

  logic [7:0]  shadow [8];
  logic [7:0]  shadow_next [8];
  logic [14:0] temp_addr;
  logic [14:0] temp_addr_next;
  logic [15:0] vaddr;
  logic [15:0] vaddr_next;
  logic [2:0]  fine_x;
  logic [2:0]  fine_x_next;
  logic        toggle;
  logic        toggle_next;

  logic [15:0] step;
  logic [15:0] mem_a;
  logic        in_nt;
  logic        in_pal;
  logic [15:0] mirror_a;

  // address decode, increment step and mirror address of a data-port write
  always_comb begin
    step   = shadow[ppu_pkg::REG_CTRL][ppu_pkg::CTRL_INC_BIT] ? ppu_pkg::STEP_ROW
                                                               : ppu_pkg::STEP_ONE;
    mem_a  = vaddr & ppu_pkg::ADDR_MASK;
    in_nt  = (mem_a >= ppu_pkg::NT_BASE) && (mem_a < ppu_pkg::NT_END);
    in_pal = (mem_a >= ppu_pkg::PAL_BASE) && (mem_a <= ppu_pkg::PAL_MIR_LAST) &&
             (mem_a[1:0] == 2'b00);
    if (in_nt) begin
      mirror_a = mem_a ^ (mirroring_mode ? ppu_pkg::NT_STEP_VERT : ppu_pkg::NT_STEP_HORZ);
    end else begin
      mirror_a = mem_a ^ ppu_pkg::PAL_MIR_STEP;
    end
    vram_addr   = mem_a[VRAM_AW-1:0];
    mirror_addr = mirror_a[VRAM_AW-1:0];
    oam_addr    = shadow[ppu_pkg::REG_OAM_ADDR][OAM_AW-1:0];
  end

  // next state and issue word of one transfer
  always_comb begin
    shadow_next    = shadow;
    temp_addr_next = temp_addr;
    vaddr_next     = vaddr;
    fine_x_next    = fine_x;
    toggle_next    = toggle;
    issue          = '0;
    mreq           = '0;
    unique case (req_type)
      ppu_pkg::REQ_READ: begin
        unique case (reg_index)
          ppu_pkg::REG_STATUS: begin
            issue.read_data = shadow[ppu_pkg::REG_STATUS];
            shadow_next[ppu_pkg::REG_STATUS] = {1'b0, shadow[ppu_pkg::REG_STATUS][6:0]};
            toggle_next = 1'b0;
          end
          ppu_pkg::REG_OAM_DATA: begin
            if (shadow[ppu_pkg::REG_STATUS][ppu_pkg::STATUS_VBLANK] ||
                (shadow[ppu_pkg::REG_MASK][4:3] == 2'b00)) begin
              mreq.oam_re  = 1'b1;
              issue.oam_rd = 1'b1;
            end
          end
          ppu_pkg::REG_DATA: begin
            mreq.vram_re  = 1'b1;
            issue.vram_rd = 1'b1;
            issue.pal_rd  = (vaddr >= ppu_pkg::PAL_BASE);
            vaddr_next    = vaddr + step;
          end
          default: begin
            issue.read_data = shadow[reg_index];
          end
        endcase
      end
      ppu_pkg::REQ_WRITE: begin
        unique case (reg_index)
          ppu_pkg::REG_CTRL: begin
            temp_addr_next[11:10] = write_data[1:0];
            issue.nmi = shadow[ppu_pkg::REG_STATUS][ppu_pkg::STATUS_VBLANK] &
                        ~shadow[ppu_pkg::REG_CTRL][ppu_pkg::CTRL_NMI_BIT] &
                        write_data[7];
          end
          ppu_pkg::REG_OAM_DATA: begin
            mreq.oam_we = 1'b1;
            shadow_next[ppu_pkg::REG_OAM_ADDR] = shadow[ppu_pkg::REG_OAM_ADDR] + 8'd1;
          end
          ppu_pkg::REG_SCROLL: begin
            if (!toggle) begin
              temp_addr_next[4:0] = write_data[7:3];
              fine_x_next         = write_data[2:0];
            end else begin
              temp_addr_next = {write_data[2:0], temp_addr[11:10], write_data[7:3],
                                temp_addr[4:0]};
            end
            toggle_next = ~toggle;
          end
          ppu_pkg::REG_ADDR: begin
            if (!toggle) begin
              temp_addr_next = {1'b0, write_data[5:0], temp_addr[7:0]};
            end else begin
              temp_addr_next = {temp_addr[14:8], write_data};
              vaddr_next     = {1'b0, temp_addr_next};
            end
            toggle_next = ~toggle;
          end
          ppu_pkg::REG_DATA: begin
            mreq.vram_we    = 1'b1;
            issue.mirror_wr = in_nt || in_pal;
            vaddr_next      = vaddr + step;
          end
          default: begin
          end
        endcase
        shadow_next[reg_index] = write_data;
      end
      ppu_pkg::REQ_STATUS: begin
        shadow_next[ppu_pkg::REG_STATUS] = write_data;
      end
      default: begin
      end
    endcase
    issue.vram_addr = vaddr_next;
    issue.temp_addr = temp_addr_next;
    issue.fine_x    = fine_x_next;
    issue.wdata     = write_data;
  end

  // latch state, updated on each accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      shadow    <= '{default: 8'h00};
      temp_addr <= '0;
      vaddr     <= '0;
      fine_x    <= '0;
      toggle    <= 1'b0;
    end else if (accept) begin
      shadow    <= shadow_next;
      temp_addr <= temp_addr_next;
      vaddr     <= vaddr_next;
      fine_x    <= fine_x_next;
      toggle    <= toggle_next;
    end
  end

endmodule

>>> hdl/ppu_resp.sv
// ---------------------------------------------------------------------------
// ppu_resp
// data-port read buffer and response output register
// ---------------------------------------------------------------------------
module ppu_resp (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  ppu_pkg::issue_t work,
  input  logic [7:0]      vram_rdata,
  input  logic [7:0]      oam_rdata,
  input  logic            rsp_stall,
  output logic            rsp_valid,
  output logic [7:0]      read_data,
  output logic            nmi_request,
  output logic [15:0]     vram_address_out,
  output logic [14:0]     temp_address_out,
  output logic [2:0]      fine_x_out
);

  logic [7:0] read_buffer;
  logic [7:0] rd;

  // read data select: buffered byte, fresh palette byte, sprite byte or register
  always_comb begin
    priority if (work.vram_rd) begin
      rd = work.pal_rd ? vram_rdata : read_buffer;
    end else if (work.oam_rd) begin
      rd = oam_rdata;
    end else begin
      rd = work.read_data;
    end
  end

  // read buffer refill on data-port reads
  always_ff @(posedge clk) begin
    if (rst) begin
      read_buffer <= '0;
    end else if (advance && work.vram_rd) begin
      read_buffer <= vram_rdata;
    end
  end

  // output register handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      read_data        <= rd;
      nmi_request      <= work.nmi;
      vram_address_out <= work.vram_addr;
      temp_address_out <= work.temp_addr;
      fine_x_out       <= work.fine_x;
    end
  end

endmodule

>>> hdl/ppu_register_port.sv
// ---------------------------------------------------------------------------
// ppu_register_port: request transfers pass stage 1 and the response output register
// throughput one transfer per cycle unless stalled; a data-port write that lands in a
// mirrored range stalls requests while its copy uses the single video-ram write port
// sync reset clears latches, shadows and pipeline; no clearing pass, rams unset
// ---------------------------------------------------------------------------
module ppu_register_port #(
  parameter int VRAM_DEPTH = 16384,
  parameter int OAM_DEPTH  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  req_type,
  input  logic [2:0]  reg_index,
  input  logic [7:0]  write_data,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  read_data,
  output logic        nmi_request,
  output logic [15:0] vram_address_out,
  output logic [14:0] temp_address_out,
  output logic [2:0]  fine_x_out
);

  localparam int VRAM_AW = $clog2(VRAM_DEPTH);
  localparam int OAM_AW  = $clog2(OAM_DEPTH);

  logic                mirroring_mode;
  logic                accept;
  logic                s1_valid;
  logic                s1_mirror;
  logic                s1_adv;
  logic                mirror_active;
  ppu_pkg::issue_t     issue;
  ppu_pkg::issue_t     s1_work;
  ppu_pkg::mem_req_t   mreq;
  logic [VRAM_AW-1:0]  vram_addr;
  logic [VRAM_AW-1:0]  mirror_addr;
  logic [VRAM_AW-1:0]  s1_mirror_addr;
  logic [OAM_AW-1:0]   oam_addr;
  logic                vram_we;
  logic [VRAM_AW-1:0]  vram_waddr;
  logic [7:0]          vram_wdata;
  logic [7:0]          vram_rdata;
  logic [7:0]          oam_rdata;

  // mirroring mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mirroring_mode <= 1'b0;
    end else if (cfg_write_en) begin
      mirroring_mode <= cfg_write_data;
    end
  end

  // handshake: hold off in reset, while the mirror write owns the port or stage 1 is stuck
  always_comb begin
    mirror_active = s1_valid && s1_mirror;
    s1_adv        = s1_valid && (!rsp_valid || !rsp_stall);
    req_stall     = rst || mirror_active || (s1_valid && !s1_adv);
    accept        = req_valid && !req_stall;
  end

  ppu_latch #(
    .VRAM_AW (VRAM_AW),
    .OAM_AW  (OAM_AW)
  ) u_latch (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .req_type       (req_type),
    .reg_index      (reg_index),
    .write_data     (write_data),
    .mirroring_mode (mirroring_mode),
    .issue          (issue),
    .mreq           (mreq),
    .vram_addr      (vram_addr),
    .mirror_addr    (mirror_addr),
    .oam_addr       (oam_addr)
  );

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_mirror <= 1'b0;
    end else if (accept) begin
      s1_valid  <= 1'b1;
      s1_mirror <= issue.mirror_wr;
    end else begin
      s1_mirror <= 1'b0;
      if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_work        <= issue;
      s1_mirror_addr <= mirror_addr;
    end
  end

  // video-ram write port: primary write on transfer, mirror copy in the following cycle
  always_comb begin
    vram_we    = mirror_active || (accept && mreq.vram_we);
    vram_waddr = mirror_active ? s1_mirror_addr : vram_addr;
    vram_wdata = mirror_active ? s1_work.wdata : write_data;
  end

  ppu_ram #(
    .WIDTH (8),
    .DEPTH (VRAM_DEPTH)
  ) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .re    (accept && mreq.vram_re),
    .raddr (vram_addr),
    .rdata (vram_rdata)
  );

  ppu_ram #(
    .WIDTH (8),
    .DEPTH (OAM_DEPTH)
  ) u_oam (
    .clk   (clk),
    .we    (accept && mreq.oam_we),
    .waddr (oam_addr),
    .wdata (write_data),
    .re    (accept && mreq.oam_re),
    .raddr (oam_addr),
    .rdata (oam_rdata)
  );

  ppu_resp u_resp (
    .clk              (clk),
    .rst              (rst),
    .advance          (s1_adv),
    .work             (s1_work),
    .vram_rdata       (vram_rdata),
    .oam_rdata        (oam_rdata),
    .rsp_stall        (rsp_stall),
    .rsp_valid        (rsp_valid),
    .read_data        (read_data),
    .nmi_request      (nmi_request),
    .vram_address_out (vram_address_out),
    .temp_address_out (temp_address_out),
    .fine_x_out       (fine_x_out)
  );

endmodule

>>> hdl/ppu_port_checker.sv
// ---------------------------------------------------------------------------
// ppu_port_checker
// port-level checks on the response side of the register port
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ppu_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [7:0]  read_data,
  input logic        nmi_request,
  input logic [15:0] vram_address_out,
  input logic [14:0] temp_address_out,
  input logic [2:0]  fine_x_out
);

  // a stalled response holds its transfer
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(read_data) && $stable(nmi_request) && $stable(vram_address_out) && $stable(temp_address_out) && $stable(fine_x_out))

  // no response right after reset
  `ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !rsp_valid)

  // an nmi comes only from a ctrl write, which returns no data
  `ASSERT_IMPLIES(a_nmi_no_data, clk, rst, rsp_valid && nmi_request, read_data == 8'd0)

endmodule

bind ppu_register_port ppu_port_checker u_port_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp_valid),
  .rsp_stall        (rsp_stall),
  .read_data        (read_data),
  .nmi_request      (nmi_request),
  .vram_address_out (vram_address_out),
  .temp_address_out (temp_address_out),
  .fine_x_out       (fine_x_out)
);
